FILE: design/sorted_frontier_deque_defines.svh
// assertion helpers used by the deque top level
`ifndef SORTED_FRONTIER_DEQUE_DEFINES_SVH
`define SORTED_FRONTIER_DEQUE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define SFD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/sfd_pkg.sv
package sfd_pkg;

  localparam int FUNC_BITS   = 3;
  localparam int STATUS_BITS = 2;

  localparam logic [FUNC_BITS-1:0] F_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_BITS-1:0] F_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_BITS-1:0] F_PRIO_INS   = 3'd2;
  localparam logic [FUNC_BITS-1:0] F_POP_FRONT  = 3'd3;
  localparam logic [FUNC_BITS-1:0] F_POP_BACK   = 3'd4;
  localparam logic [FUNC_BITS-1:0] F_MOVE_FRONT = 3'd5;
  localparam logic [FUNC_BITS-1:0] F_PRIO_MOVE  = 3'd6;
  localparam logic [FUNC_BITS-1:0] F_POP_MIN    = 3'd7;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd3;

  // per-cell move command, load wins over left, left over right
  typedef struct packed {
    logic load;
    logic from_left;
    logic from_right;
  } sfd_ctl_t;

endpackage

FILE: design/sorted_frontier_deque.sv
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+---------------------------
// command   | func_i, node_id_i, label_i                   | start && !busy
// result    | out_node_id_o, out_label_o, status_o,        | result_valid_o, one cycle
//           | occupancy_o                                  |
//
// pushes and pops run find then apply; move to front and priority insert
// compare first; priority move runs compare, find, apply twice; pop minimum
// runs the bit search first, which retires one label bit per cycle across the cell row.
// a full, empty or not-found outcome ends at the find step.
// rst_ni clears the count and control; cell contents are not reset.
// the result is a one-cycle strobe and cannot be stalled; busy drops with it.
module sorted_frontier_deque
  import sfd_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int ID_BITS    = 16,
  parameter int LABEL_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [FUNC_BITS-1:0]          func_i,
  input  logic [ID_BITS-1:0]            node_id_i,
  input  logic [LABEL_BITS-1:0]         label_i,
  output logic                          result_valid_o,
  output logic [ID_BITS-1:0]            out_node_id_o,
  output logic [LABEL_BITS-1:0]         out_label_o,
  output logic [STATUS_BITS-1:0]        status_o,
  output logic [$clog2(DEPTH+1)-1:0]    occupancy_o
);

`include "sorted_frontier_deque_defines.svh"

  localparam int CW = $clog2(DEPTH+1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_MIN   = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [FUNC_BITS-1:0]  func_q, func_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [LABEL_BITS-1:0] lab_q, lab_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  ph2_q, ph2_d;
  logic [DEPTH-1:0]      flag_q, flag_d;
  logic [DEPTH-1:0]      alive_q, alive_d;
  logic [DEPTH-1:0]      pos_q, pos_d;
  logic [LABEL_BITS-1:0] bmask_q, bmask_d;

  logic                   done_q, done_d;
  logic [ID_BITS-1:0]     oid_q, oid_d;
  logic [LABEL_BITS-1:0]  olab_q, olab_d;
  logic [STATUS_BITS-1:0] ost_q, ost_d;
  logic [CW-1:0]          occ_q, occ_d;

  logic [DEPTH-1:0]      valid, cnt_oh, tail_oh, eq_v, gt_v, bit_v;
  logic [ID_BITS-1:0]    cell_id [DEPTH];
  logic [LABEL_BITS-1:0] cell_lab [DEPTH];
  sfd_ctl_t              ctl [DEPTH];

  logic [DEPTH-1:0] first_flag, first_alive, ins_pos, z_v, after_v, upto_v;
  logic [ID_BITS-1:0]    sel_id;
  logic [LABEL_BITS-1:0] sel_lab;
  logic ins_mode, is_insert, is_drop, full, empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]    l_id, r_id;
    logic [LABEL_BITS-1:0] l_lab, r_lab;
    if (i == 0) begin : g_first
      assign l_id  = '0;
      assign l_lab = '0;
    end else begin : g_mid
      assign l_id  = cell_id[i-1];
      assign l_lab = cell_lab[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign r_id  = '0;
      assign r_lab = '0;
    end else begin : g_inner
      assign r_id  = cell_id[i+1];
      assign r_lab = cell_lab[i+1];
    end

    sfd_cell #(
      .ID_BITS    (ID_BITS),
      .LABEL_BITS (LABEL_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl[i]),
      .left_id_i   (l_id),
      .left_lab_i  (l_lab),
      .right_id_i  (r_id),
      .right_lab_i (r_lab),
      .key_id_i    (id_q),
      .key_lab_i   (lab_q),
      .bit_mask_i  (bmask_q),
      .id_o        (cell_id[i]),
      .lab_o       (cell_lab[i]),
      .eq_o        (eq_v[i]),
      .gt_o        (gt_v[i]),
      .bit_o       (bit_v[i])
    );

    assign valid[i]   = (CW'(i) < count_q);
    assign cnt_oh[i]  = (count_q == CW'(i));
    assign tail_oh[i] = (count_q == CW'(i + 1));
  end

  assign full        = (count_q == CW'(DEPTH));
  assign empty       = (count_q == '0);
  assign ins_mode    = (func_q == F_PRIO_INS) || ((func_q == F_PRIO_MOVE) && ph2_q);
  assign first_flag  = flag_q & (~flag_q + DEPTH'(1));
  assign first_alive = alive_q & (~alive_q + DEPTH'(1));
  assign ins_pos     = (flag_q == '0) ? cnt_oh : first_flag;
  assign z_v         = alive_q & ~bit_v;
  assign after_v     = ~(pos_q - DEPTH'(1));
  assign upto_v      = (pos_q - DEPTH'(1)) | pos_q;
  assign is_insert   = (func_q == F_PUSH_FRONT) || (func_q == F_PUSH_BACK) || ins_mode;
  assign is_drop     = (func_q == F_POP_FRONT) || (func_q == F_POP_BACK) ||
                       (func_q == F_POP_MIN) || ((func_q == F_PRIO_MOVE) && !ph2_q);

  // one-hot select of the removed entry
  always_comb begin
    sel_id  = '0;
    sel_lab = '0;
    for (int k = 0; k < DEPTH; k++) begin
      sel_id  = sel_id  | (pos_q[k] ? cell_id[k]  : '0);
      sel_lab = sel_lab | (pos_q[k] ? cell_lab[k] : '0);
    end
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      ctl[k] = '0;
      if (state_q == S_APPLY) begin
        if (is_insert) begin
          ctl[k].load      = pos_q[k];
          ctl[k].from_left = after_v[k] & ~pos_q[k];
        end else if (is_drop) begin
          ctl[k].from_right = after_v[k];
        end else begin
          ctl[k].load      = (k == 0);
          ctl[k].from_left = upto_v[k] & (k != 0);
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    id_d    = id_q;
    lab_d   = lab_q;
    count_d = count_q;
    ph2_d   = ph2_q;
    flag_d  = flag_q;
    alive_d = alive_q;
    pos_d   = pos_q;
    bmask_d = bmask_q;
    done_d  = 1'b0;
    oid_d   = '0;
    olab_d  = '0;
    ost_d   = ST_OK;
    occ_d   = count_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d  = func_i;
          id_d    = node_id_i;
          lab_d   = label_i;
          ph2_d   = 1'b0;
          alive_d = valid;
          bmask_d = {1'b1, {(LABEL_BITS-1){1'b0}}};
          case (func_i)
            F_PRIO_INS, F_MOVE_FRONT, F_PRIO_MOVE: state_d = S_CMP;
            F_POP_MIN:                             state_d = S_MIN;
            default:                               state_d = S_FIND;
          endcase
        end
      end
      S_CMP: begin
        flag_d  = valid & (ins_mode ? ~gt_v : eq_v);
        state_d = S_FIND;
      end
      S_MIN: begin
        // keep survivors whose current label bit is zero, msb first
        if (z_v != '0) alive_d = z_v;
        bmask_d = bmask_q >> 1;
        if (bmask_q[0]) state_d = S_FIND;
      end
      S_FIND: begin
        state_d = S_APPLY;
        case (func_q)
          F_PUSH_FRONT: pos_d = DEPTH'(1);
          F_PUSH_BACK:  pos_d = cnt_oh;
          F_PRIO_INS:   pos_d = ins_pos;
          F_POP_FRONT:  pos_d = DEPTH'(1);
          F_POP_BACK:   pos_d = tail_oh;
          F_POP_MIN:    pos_d = first_alive;
          F_MOVE_FRONT: pos_d = first_flag;
          F_PRIO_MOVE:  pos_d = ph2_q ? ins_pos : first_flag;
          default:      pos_d = '0;
        endcase
        if (is_insert && full && !ph2_q) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          ost_d   = ST_FULL;
        end else if (is_drop && (func_q != F_PRIO_MOVE) && empty) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          ost_d   = ST_EMPTY;
        end else if (((func_q == F_MOVE_FRONT) || ((func_q == F_PRIO_MOVE) && !ph2_q)) &&
                     (flag_q == '0)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          ost_d   = ST_MISSING;
        end
      end
      S_APPLY: begin
        if (is_insert) begin
          count_d = count_q + CW'(1);
        end else if (is_drop) begin
          count_d = count_q - CW'(1);
        end
        if ((func_q == F_PRIO_MOVE) && !ph2_q) begin
          // removed, now reinsert by label against the shortened row
          ph2_d   = 1'b1;
          state_d = S_CMP;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          occ_d   = count_d;
          if (is_drop) begin
            oid_d  = sel_id;
            olab_d = sel_lab;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ph2_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ph2_q   <= ph2_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    id_q    <= id_d;
    lab_q   <= lab_d;
    flag_q  <= flag_d;
    alive_q <= alive_d;
    pos_q   <= pos_d;
    bmask_q <= bmask_d;
    oid_q   <= oid_d;
    olab_q  <= olab_d;
    ost_q   <= ost_d;
    occ_q   <= occ_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = done_q;
  assign out_node_id_o  = oid_q;
  assign out_label_o    = olab_q;
  assign status_o       = ost_q;
  assign occupancy_o    = occ_q;

  `SFD_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count above depth")
  `SFD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `SFD_ASSERT(a_result_idle, !result_valid_o || !busy, "result strobe while still busy")
  `SFD_ASSERT(a_full_occ, !(result_valid_o && status_o == ST_FULL) || occupancy_o == CW'(DEPTH), "full status with room left")

endmodule

FILE: design/sfd_cell.sv
module sfd_cell
  import sfd_pkg::*;
#(
  parameter int ID_BITS    = 16,
  parameter int LABEL_BITS = 32
) (
  input  logic                  clk_i,
  input  sfd_ctl_t              ctl_i,
  input  logic [ID_BITS-1:0]    left_id_i,
  input  logic [LABEL_BITS-1:0] left_lab_i,
  input  logic [ID_BITS-1:0]    right_id_i,
  input  logic [LABEL_BITS-1:0] right_lab_i,
  input  logic [ID_BITS-1:0]    key_id_i,
  input  logic [LABEL_BITS-1:0] key_lab_i,
  input  logic [LABEL_BITS-1:0] bit_mask_i,
  output logic [ID_BITS-1:0]    id_o,
  output logic [LABEL_BITS-1:0] lab_o,
  output logic                  eq_o,
  output logic                  gt_o,
  output logic                  bit_o
);

  logic [ID_BITS-1:0]    id_q, id_d;
  logic [LABEL_BITS-1:0] lab_q, lab_d;

  always_comb begin
    id_d  = id_q;
    lab_d = lab_q;
    if (ctl_i.load) begin
      id_d  = key_id_i;
      lab_d = key_lab_i;
    end else if (ctl_i.from_left) begin
      id_d  = left_id_i;
      lab_d = left_lab_i;
    end else if (ctl_i.from_right) begin
      id_d  = right_id_i;
      lab_d = right_lab_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    lab_q <= lab_d;
  end

  assign id_o  = id_q;
  assign lab_o = lab_q;
  assign eq_o  = (id_q == key_id_i);
  assign gt_o  = (lab_q > key_lab_i);
  assign bit_o = |(lab_q & bit_mask_i);

endmodule
